[rtl/core/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg
// Shared widths, codes and types of the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

   localparam int OP_W      = 2;
   localparam int LEN_W     = 4;
   localparam int DATA_W    = 64;
   localparam int CNT_W     = 11;
   localparam int BYTE_W    = 8;
   localparam int MAX_LANES = 8;

   localparam int DEF_STORE_DEPTH = 1024;
   localparam int DEF_LANES       = 8;

   localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [OP_W-1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_PEEK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_NO_DATA  = 2'd2
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [LEN_W-1:0]   moved;
      logic [CNT_W-1:0]   fill;
      logic               rd_ok;
   } meta_type;

endpackage

[rtl/core/brf_if.sv]
// ----------------------------------------------------------------------------
// brf_req_if / brf_rsp_if
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface brf_req_if;
   import brf_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [LEN_W-1:0]  length;
   logic [DATA_W-1:0] payload;

   modport source (output valid, output operation, output length, output payload,
                   input ready);
   modport sink   (input valid, input operation, input length, input payload,
                   output ready);
endinterface

interface brf_rsp_if;
   import brf_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [LEN_W-1:0]  moved;
   logic [DATA_W-1:0] read_bytes;
   logic [CNT_W-1:0]  fill_level;

   modport source (output valid, output status, output moved, output read_bytes,
                   output fill_level, input ready);
   modport sink   (input valid, input status, input moved, input read_bytes,
                   input fill_level, output ready);
endinterface

[rtl/core/brf_lane.sv]
// ----------------------------------------------------------------------------
// brf_lane
// One byte bank of the store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module brf_lane #(
   parameter int ROWS  = 128,
   parameter int ROW_W = 7
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [ROW_W-1:0]         waddr,
   input  logic [brf_pkg::BYTE_W-1:0] wdata,
   input  logic                     re,
   input  logic [ROW_W-1:0]         raddr,
   output logic [brf_pkg::BYTE_W-1:0] rdata
);
   import brf_pkg::*;

   logic [BYTE_W-1:0] mem [ROWS];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/brf_ctrl.sv]
// ----------------------------------------------------------------------------
// brf_ctrl
// Capacity register, ring pointers and fill count; decides each item and
// drives the bank write and read addresses.
// ----------------------------------------------------------------------------
module brf_ctrl #(
   parameter int STORE_DEPTH = 1024,
   parameter int LANES       = 8,
   parameter int LANE_W      = 3,
   parameter int ROWS        = 128,
   parameter int ROW_W       = 7
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [brf_pkg::CNT_W-1:0]              csr_wdata,
   input  logic                                   accept,
   input  logic [brf_pkg::OP_W-1:0]               operation,
   input  logic [brf_pkg::LEN_W-1:0]              length,
   input  logic [brf_pkg::DATA_W-1:0]             payload,
   output logic [LANES-1:0]                       lane_we,
   output logic [LANES-1:0][ROW_W-1:0]            lane_waddr,
   output logic [LANES-1:0][brf_pkg::BYTE_W-1:0]  lane_wdata,
   output logic [LANES-1:0][ROW_W-1:0]            lane_raddr,
   output brf_pkg::meta_type                      meta,
   output logic [LANE_W-1:0]                      rd_lane
);
   import brf_pkg::*;

   logic [CNT_W-1:0]  capacity_ff, capacity_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LANE_W-1:0] wr_lane_ff, wr_lane_in, rd_lane_ff, rd_lane_in;
   logic [ROW_W-1:0]  wr_row_ff, wr_row_in, rd_row_ff, rd_row_in;

   logic [CNT_W-1:0]  cap_eff;
   logic [LEN_W-1:0]  len_sat;
   op_type            op;
   logic [CNT_W:0]    sum_fill;
   logic              enq_ok, rd_ok_c;
   status_type        status_c;
   logic [CNT_W-1:0]  fill_c;
   logic [LANE_W:0]   wr_lane_sum, rd_lane_sum;
   logic [ROW_W-1:0]  wr_row_inc, rd_row_inc;

   always_comb begin
      if (int'(capacity_ff) > STORE_DEPTH) begin
         cap_eff = CNT_W'(STORE_DEPTH);
      end else begin
         cap_eff = capacity_ff;
      end
   end

   assign len_sat  = (length > LEN_W'(LANES)) ? LEN_W'(LANES) : length;
   assign op       = op_type'(operation);
   assign sum_fill = (CNT_W+1)'(cnt_ff) + (CNT_W+1)'(len_sat);
   assign enq_ok   = (op == OP_ENQ) && (sum_fill <= (CNT_W+1)'(cap_eff));
   assign rd_ok_c  = ((op == OP_DEQ) || (op == OP_PEEK)) && (CNT_W'(len_sat) <= cnt_ff);

   always_comb begin
      unique case (op)
         OP_ENQ:          status_c = enq_ok ? ST_OK : ST_NO_SPACE;
         OP_DEQ, OP_PEEK: status_c = rd_ok_c ? ST_OK : ST_NO_DATA;
         default:         status_c = ST_OK;
      endcase
   end

   always_comb begin
      if (enq_ok) begin
         fill_c = sum_fill[CNT_W-1:0];
      end else if (rd_ok_c && (op == OP_DEQ)) begin
         fill_c = cnt_ff - CNT_W'(len_sat);
      end else begin
         fill_c = cnt_ff;
      end
   end

   assign meta.status = status_c;
   assign meta.moved  = (enq_ok || rd_ok_c) ? len_sat : '0;
   assign meta.fill   = fill_c;
   assign meta.rd_ok  = rd_ok_c;
   assign rd_lane     = rd_lane_ff;

   // pointer arithmetic: lane within a row, row wraps over the bank depth
   assign wr_row_inc  = (wr_row_ff == ROW_W'(ROWS - 1)) ? '0 : wr_row_ff + 1'b1;
   assign rd_row_inc  = (rd_row_ff == ROW_W'(ROWS - 1)) ? '0 : rd_row_ff + 1'b1;
   assign wr_lane_sum = (LANE_W+1)'(wr_lane_ff) + (LANE_W+1)'(len_sat);
   assign rd_lane_sum = (LANE_W+1)'(rd_lane_ff) + (LANE_W+1)'(len_sat);

   genvar b;
   for (b = 0; b < LANES; b++) begin : g_lane
      logic [LANE_W:0] wd;
      logic [LANE_W:0] wi;

      assign wd = (LANE_W+1)'(b + LANES) - (LANE_W+1)'(wr_lane_ff);
      assign wi = (wd >= (LANE_W+1)'(LANES)) ? wd - (LANE_W+1)'(LANES) : wd;

      assign lane_we[b]    = accept && enq_ok && (LEN_W'(wi) < len_sat);
      assign lane_waddr[b] = (LANE_W'(b) < wr_lane_ff) ? wr_row_inc : wr_row_ff;
      assign lane_wdata[b] = payload[BYTE_W*wi +: BYTE_W];
      assign lane_raddr[b] = (LANE_W'(b) < rd_lane_ff) ? rd_row_inc : rd_row_ff;
   end

   always_comb begin
      capacity_in = capacity_ff;
      cnt_in      = cnt_ff;
      wr_lane_in  = wr_lane_ff;
      wr_row_in   = wr_row_ff;
      rd_lane_in  = rd_lane_ff;
      rd_row_in   = rd_row_ff;
      if (csr_we) begin
         capacity_in = csr_wdata;
         cnt_in      = '0;
         wr_lane_in  = '0;
         wr_row_in   = '0;
         rd_lane_in  = '0;
         rd_row_in   = '0;
      end else if (accept) begin
         cnt_in = fill_c;
         if (enq_ok) begin
            if (wr_lane_sum >= (LANE_W+1)'(LANES)) begin
               wr_lane_in = LANE_W'(wr_lane_sum - (LANE_W+1)'(LANES));
               wr_row_in  = wr_row_inc;
            end else begin
               wr_lane_in = LANE_W'(wr_lane_sum);
            end
         end
         if (rd_ok_c && (op == OP_DEQ)) begin
            if (rd_lane_sum >= (LANE_W+1)'(LANES)) begin
               rd_lane_in = LANE_W'(rd_lane_sum - (LANE_W+1)'(LANES));
               rd_row_in  = rd_row_inc;
            end else begin
               rd_lane_in = LANE_W'(rd_lane_sum);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         cnt_ff      <= '0;
         wr_lane_ff  <= '0;
         wr_row_ff   <= '0;
         rd_lane_ff  <= '0;
         rd_row_ff   <= '0;
      end else begin
         capacity_ff <= capacity_in;
         cnt_ff      <= cnt_in;
         wr_lane_ff  <= wr_lane_in;
         wr_row_ff   <= wr_row_in;
         rd_lane_ff  <= rd_lane_in;
         rd_row_ff   <= rd_row_in;
      end
   end

`ifndef SYNTHESIS
   a_fill_within_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= cap_eff)
      else $error("fill count above effective capacity");

   a_peek_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_we && (op == OP_PEEK)) |=>
         ($stable(rd_row_ff) && $stable(rd_lane_ff) && $stable(cnt_ff)))
      else $error("peek changed read pointer or fill count");
`endif

endmodule

[rtl/core/brf_merge.sv]
// ----------------------------------------------------------------------------
// brf_merge
// Holds the bank read data of an item, rotates the lanes into item order
// and registers the response item.
// ----------------------------------------------------------------------------
module brf_merge #(
   parameter int LANES  = 8,
   parameter int LANE_W = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  brf_pkg::meta_type                     meta_in,
   input  logic [LANE_W-1:0]                     rd_lane_in,
   input  logic [LANES-1:0][brf_pkg::BYTE_W-1:0] bank_q,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [brf_pkg::LEN_W-1:0]             rsp_moved,
   output logic [brf_pkg::DATA_W-1:0]            rsp_read_bytes,
   output logic [brf_pkg::CNT_W-1:0]             rsp_fill_level,
   output logic                                  s1_free
);
   import brf_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   meta_type          s1_meta_ff;
   logic [LANE_W-1:0] s1_lane_ff;
   logic              s2_valid_ff, s2_valid_in;
   meta_type          s2_meta_ff;
   logic [DATA_W-1:0] s2_bytes_ff;
   logic              s2_adv, s1_fire;
   logic [DATA_W-1:0] bytes_c;

   assign s2_adv  = !s2_valid_ff || rsp_ready;
   assign s1_fire = s1_valid_ff && s2_adv;
   assign s1_free = !s1_valid_ff || s2_adv;

   genvar i;
   for (i = 0; i < MAX_LANES; i++) begin : g_byte
      if (i < LANES) begin : g_used
         logic [LANE_W:0]   src_sum;
         logic [LANE_W-1:0] src;

         assign src_sum = (LANE_W+1)'(s1_lane_ff) + (LANE_W+1)'(i);
         assign src     = (src_sum >= (LANE_W+1)'(LANES)) ?
                          LANE_W'(src_sum - (LANE_W+1)'(LANES)) : LANE_W'(src_sum);
         assign bytes_c[BYTE_W*i +: BYTE_W] =
            (s1_meta_ff.rd_ok && (LEN_W'(i) < s1_meta_ff.moved)) ? bank_q[src] : '0;
      end else begin : g_unused
         assign bytes_c[BYTE_W*i +: BYTE_W] = '0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_fire) begin
         s2_valid_in = 1'b1;
      end else if (rsp_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (accept) begin
         s1_meta_ff <= meta_in;
         s1_lane_ff <= rd_lane_in;
      end
      if (s1_fire) begin
         s2_meta_ff  <= s1_meta_ff;
         s2_bytes_ff <= bytes_c;
      end
   end

   assign rsp_valid      = s2_valid_ff;
   assign rsp_status     = s2_meta_ff.status;
   assign rsp_moved      = s2_meta_ff.moved;
   assign rsp_read_bytes = s2_bytes_ff;
   assign rsp_fill_level = s2_meta_ff.fill;

`ifndef SYNTHESIS
   a_accept_needs_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> s1_free)
      else $error("item taken while holding stage was full");

   a_refused_is_empty: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && (s2_meta_ff.status != ST_OK)) |->
         ((s2_meta_ff.moved == '0) && (s2_bytes_ff == '0)))
      else $error("refused item carries data");
`endif

endmodule

[rtl/core/byte_ring_fifo_unit.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_unit
// Byte FIFO in a ring of byte-wide banks with all-or-nothing transfers.
// ----------------------------------------------------------------------------
// One request item per clock cycle is taken unless the response side stalls;
// each item passes the bank read register, then lane rotation into the output
// register. The store is split into LANES byte banks, each with one write
// and one read per cycle, so an item of up to LANES bytes touches every bank
// at most once. A capacity write empties the buffer and takes effect at once.
module byte_ring_fifo_unit #(
   parameter int STORE_DEPTH = brf_pkg::DEF_STORE_DEPTH,
   parameter int LANES       = brf_pkg::DEF_LANES
) (
   input  logic                      clock,
   input  logic                      reset,
   brf_req_if.sink                   req_chan,
   brf_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [brf_pkg::CNT_W-1:0] csr_wdata
);
   import brf_pkg::*;

   localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int ROWS   = (STORE_DEPTH + LANES - 1) / LANES;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic                           accept;
   logic                           s1_free;
   logic [LANES-1:0]               lane_we;
   logic [LANES-1:0][ROW_W-1:0]    lane_waddr;
   logic [LANES-1:0][BYTE_W-1:0]   lane_wdata;
   logic [LANES-1:0][ROW_W-1:0]    lane_raddr;
   logic [LANES-1:0][BYTE_W-1:0]   bank_q;
   meta_type                       meta;
   logic [LANE_W-1:0]              rd_lane;

   assign req_chan.ready = s1_free;
   assign accept         = req_chan.valid && s1_free;

   brf_ctrl #(
      .STORE_DEPTH (STORE_DEPTH),
      .LANES       (LANES),
      .LANE_W      (LANE_W),
      .ROWS        (ROWS),
      .ROW_W       (ROW_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .operation  (req_chan.operation),
      .length     (req_chan.length),
      .payload    (req_chan.payload),
      .lane_we    (lane_we),
      .lane_waddr (lane_waddr),
      .lane_wdata (lane_wdata),
      .lane_raddr (lane_raddr),
      .meta       (meta),
      .rd_lane    (rd_lane)
   );

   genvar b;
   for (b = 0; b < LANES; b++) begin : g_bank
      brf_lane #(
         .ROWS  (ROWS),
         .ROW_W (ROW_W)
      ) u_lane (
         .clock (clock),
         .we    (lane_we[b]),
         .waddr (lane_waddr[b]),
         .wdata (lane_wdata[b]),
         .re    (accept),
         .raddr (lane_raddr[b]),
         .rdata (bank_q[b])
      );
   end

   brf_merge #(
      .LANES  (LANES),
      .LANE_W (LANE_W)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .meta_in        (meta),
      .rd_lane_in     (rd_lane),
      .bank_q         (bank_q),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_status     (rsp_chan.status),
      .rsp_moved      (rsp_chan.moved),
      .rsp_read_bytes (rsp_chan.read_bytes),
      .rsp_fill_level (rsp_chan.fill_level),
      .s1_free        (s1_free)
   );

endmodule

[tb/sv/byte_ring_fifo_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_unit_tb
// Self-checking bench for the byte ring FIFO. Enqueue, dequeue, peek and idle
// items go in through the request channel. Each item's reply is worked out by
// a ring model held in the bench and compared field by field with the block's
// reply. The run covers directed corners, capacity saturation and wrap-round,
// a long reply stall that backs up the input, and random traffic over a range
// of capacities with random gaps on both channels.
// ----------------------------------------------------------------------------
module byte_ring_fifo_unit_tb;
   import brf_pkg::*;

   localparam int RING_DEPTH  = DEF_STORE_DEPTH;
   localparam int RING_LANES  = DEF_LANES;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_LEN    = 150;

   typedef struct {
      status_type        status;
      logic [LEN_W-1:0]  moved;
      logic [DATA_W-1:0] read_bytes;
      logic [CNT_W-1:0]  fill;
   } ring_reply_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CNT_W-1:0] csr_wdata;

   brf_req_if req_chan ();
   brf_rsp_if rsp_chan ();

   byte_ring_fifo_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // ring model
   logic [7:0]       ring_bytes [RING_DEPTH];
   int unsigned      head_slot;
   int unsigned      tail_slot;
   int unsigned      ring_level;
   logic [CNT_W-1:0] capacity_reg;
   ring_reply_type   due_replies [$];

   bit sender_idle;
   bit receiver_idle;
   int hold_cycles;

   int items_sent;
   int replies_checked;
   int refusals;
   int mismatches;
   int input_stalls;
   int cycle_count;

   always #10 clock = ~clock;

   function automatic int unsigned live_capacity();
      return (capacity_reg > RING_DEPTH) ? RING_DEPTH : capacity_reg;
   endfunction

   function automatic int unsigned next_slot(int unsigned slot, int unsigned cap);
      return (slot + 1 >= cap) ? 0 : slot + 1;
   endfunction

   function automatic void clear_ring();
      head_slot  = 0;
      tail_slot  = 0;
      ring_level = 0;
   endfunction

   function automatic int pick_gap(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 40);
   endfunction

   function automatic logic [DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void apply_transfer(op_type op, logic [LEN_W-1:0] len_in,
                                          logic [DATA_W-1:0] data);
      ring_reply_type r;
      int unsigned len;
      int unsigned cap;
      int unsigned slot;
      int unsigned space;
      r.status     = ST_OK;
      r.moved      = '0;
      r.read_bytes = '0;
      len = (len_in > RING_LANES) ? RING_LANES : len_in;
      cap = live_capacity();
      case (op)
         OP_ENQ: begin
            space = (cap > ring_level) ? cap - ring_level : 0;
            if (len > space) begin
               r.status = ST_NO_SPACE;
            end else begin
               for (int i = 0; i < len; i++) begin
                  ring_bytes[tail_slot] = data[8*i +: 8];
                  tail_slot = next_slot(tail_slot, cap);
               end
               ring_level += len;
               r.moved = LEN_W'(len);
            end
         end
         OP_DEQ, OP_PEEK: begin
            if (len > ring_level) begin
               r.status = ST_NO_DATA;
            end else begin
               slot = head_slot;
               for (int i = 0; i < len; i++) begin
                  r.read_bytes[8*i +: 8] = ring_bytes[slot];
                  slot = next_slot(slot, cap);
               end
               if (op == OP_DEQ) begin
                  head_slot = slot;
                  ring_level -= len;
               end
               r.moved = LEN_W'(len);
            end
         end
         default: ;
      endcase
      r.fill = CNT_W'(ring_level);
      due_replies.push_back(r);
   endfunction

   task automatic offer_transfer(op_type op, logic [LEN_W-1:0] len,
                                 logic [DATA_W-1:0] data);
      int gap;
      gap = pick_gap(sender_idle);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.length    <= len;
      req_chan.payload   <= data;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      apply_transfer(op, len, data);
      items_sent++;
   endtask

   task automatic offer_random_item();
      op_type           op;
      logic [LEN_W-1:0] len;
      int unsigned      cap;
      int               r;
      cap = live_capacity();
      r = $urandom_range(0, 99);
      if (r < 15) begin
         op  = op_type'($urandom_range(0, 3));
         len = LEN_W'($urandom_range(0, 15));
      end else begin
         r = $urandom_range(0, 99);
         if (ring_level * 4 > cap * 3)
            op = (r < 30) ? OP_ENQ : (r < 85) ? OP_DEQ : OP_PEEK;
         else
            op = (r < 55) ? OP_ENQ : (r < 85) ? OP_DEQ : OP_PEEK;
         len = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 8));
      end
      offer_transfer(op, len, rand64());
   endtask

   task automatic wait_replies_done();
      while (due_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CNT_W-1:0] value);
      req_chan.valid <= 1'b0;
      wait_replies_done();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      capacity_reg = value;
      clear_ring();
   endtask

   task automatic test_directed();
      offer_transfer(OP_PEEK, 4'd1, '0);
      offer_transfer(OP_DEQ, 4'd8, '0);
      offer_transfer(OP_ENQ, 4'd0, '1);
      offer_transfer(OP_DEQ, 4'd0, '0);
      offer_transfer(OP_PEEK, 4'd0, '0);
      offer_transfer(OP_ENQ, 4'd8, '1);
      offer_transfer(OP_ENQ, 4'd15, 64'h0123_4567_89ab_cdef);
      offer_transfer(OP_ENQ, 4'd3, 64'hdead_beef_00a5_5aff);
      offer_transfer(OP_NONE, 4'd5, rand64());
      offer_transfer(OP_PEEK, 4'd8, '0);
      offer_transfer(OP_PEEK, 4'd15, '0);
      offer_transfer(OP_DEQ, 4'd5, '0);
      offer_transfer(OP_DEQ, 4'd15, '0);
      offer_transfer(OP_DEQ, 4'd8, '0);
      offer_transfer(OP_PEEK, 4'd6, '0);
      offer_transfer(OP_DEQ, 4'd6, '0);
      offer_transfer(OP_ENQ, 4'd9, '0);
      offer_transfer(OP_DEQ, 4'd8, '1);
   endtask

   task automatic test_capacity_corners();
      write_capacity(11'd0);
      offer_transfer(OP_ENQ, 4'd1, rand64());
      offer_transfer(OP_ENQ, 4'd0, rand64());
      offer_transfer(OP_NONE, 4'd0, '0);
      offer_transfer(OP_DEQ, 4'd1, '0);
      write_capacity(11'd1);
      offer_transfer(OP_ENQ, 4'd1, rand64());
      offer_transfer(OP_ENQ, 4'd1, rand64());
      offer_transfer(OP_PEEK, 4'd1, '0);
      offer_transfer(OP_DEQ, 4'd1, '0);
      offer_transfer(OP_ENQ, 4'd1, rand64());
      offer_transfer(OP_DEQ, 4'd1, '0);
      // rewriting the same capacity still empties the ring
      write_capacity(11'd5);
      offer_transfer(OP_ENQ, 4'd3, rand64());
      write_capacity(11'd5);
      offer_transfer(OP_PEEK, 4'd1, '0);
      offer_transfer(OP_ENQ, 4'd5, rand64());
      offer_transfer(OP_ENQ, 4'd1, rand64());
   endtask

   task automatic test_fill_and_drain();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      // capacity above the store depth saturates, so the ring holds 1024
      write_capacity(11'd2047);
      repeat (RING_DEPTH / RING_LANES) offer_transfer(OP_ENQ, 4'd8, rand64());
      offer_transfer(OP_ENQ, 4'd1, rand64());
      repeat (2) offer_transfer(OP_DEQ, 4'd8, '0);
      repeat (2) offer_transfer(OP_ENQ, 4'd8, rand64());
      offer_transfer(OP_PEEK, 4'd8, '0);
      repeat (RING_DEPTH / RING_LANES) offer_transfer(OP_DEQ, 4'd8, '0);
      offer_transfer(OP_DEQ, 4'd1, '0);
   endtask

   task automatic test_backpressure();
      write_capacity(11'd64);
      sender_idle = 1'b0;
      hold_cycles = HOLD_LEN;
      repeat (40) offer_random_item();
   endtask

   task automatic test_random();
      logic [CNT_W-1:0] caps [10];
      caps = '{11'd1024, 11'd1, 11'd2, 11'd7, 11'd13, 11'd100, 11'd1025, 11'd0,
               11'd2047, 11'd9};
      foreach (caps[k]) begin
         write_capacity(caps[k]);
         sender_idle   = ($urandom_range(0, 3) != 0);
         receiver_idle = ($urandom_range(0, 3) != 0);
         repeat (31) offer_random_item();
      end
   endtask

   // reply side
   initial begin : reply_sink
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            stall_left  = hold_cycles;
            hold_cycles = 0;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = pick_gap(1'b1);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      ring_reply_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (due_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("reply with nothing outstanding: status %0d moved %0d bytes %h fill %0d",
                        rsp_chan.status, rsp_chan.moved, rsp_chan.read_bytes,
                        rsp_chan.fill_level);
         end else begin
            want = due_replies.pop_front();
            replies_checked++;
            if (want.status != ST_OK)
               refusals++;
            if (rsp_chan.status !== want.status || rsp_chan.moved !== want.moved ||
                rsp_chan.read_bytes !== want.read_bytes ||
                rsp_chan.fill_level !== want.fill) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("reply %0d wrong: expected status %0d moved %0d bytes %h fill %0d",
                           replies_checked, want.status, want.moved, want.read_bytes,
                           want.fill);
                  $display("   got status %0d moved %0d bytes %h fill %0d",
                           rsp_chan.status, rsp_chan.moved, rsp_chan.read_bytes,
                           rsp_chan.fill_level);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_chan.valid === 1'b1 && req_chan.ready !== 1'b1)
         input_stalls++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                  due_replies.size());
         $display("byte_ring_fifo_unit_tb failed");
         $finish;
      end
   end

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= '0;
      req_chan.length    <= '0;
      req_chan.payload   <= '0;
      sender_idle     = 1'b1;
      receiver_idle   = 1'b1;
      hold_cycles     = 0;
      items_sent      = 0;
      replies_checked = 0;
      refusals        = 0;
      mismatches      = 0;
      input_stalls    = 0;
      cycle_count     = 0;
      foreach (ring_bytes[k]) ring_bytes[k] = '0;
      capacity_reg = CAP_RESET;
      clear_ring();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_capacity_corners();
      test_fill_and_drain();
      test_backpressure();
      test_random();

      req_chan.valid <= 1'b0;
      wait_replies_done();
      repeat (6) @(posedge clock);
      mismatches += due_replies.size();

      $display("%0d items sent, %0d replies checked, %0d refused by status",
               items_sent, replies_checked, refusals);
      $display("covered full and empty ring, wrap-round, many capacities, input stalled %0d cycles",
               input_stalls);
      if (mismatches == 0) begin
         $display("byte_ring_fifo_unit_tb passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("byte_ring_fifo_unit_tb failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/brf_pkg.sv
rtl/core/brf_if.sv
rtl/core/brf_lane.sv
rtl/core/brf_ctrl.sv
rtl/core/brf_merge.sv
rtl/core/byte_ring_fifo_unit.sv
tb/sv/byte_ring_fifo_unit_tb.sv
